FILE: rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB565 conversion package
// Shared payload types, pipeline tags, sector codes and fixed-point constants.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   // Full circle of the fraction, and the divisor 255 * 65536 with its half
   localparam logic [16:0] FRAC_ONE    = 17'h10000;
   localparam logic [23:0] DIVISOR     = 24'd16711680;
   localparam logic [31:0] HALF_DIV    = 32'd8355840;
   localparam logic [7:0]  CHAN_MAX    = 8'd255;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } hsvrgb_sector_type;

   typedef struct packed {
      logic [15:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
   } hsvrgb_req_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] packed_565;
   } hsvrgb_rsp_type;

   typedef struct packed {
      logic              valid;
      hsvrgb_sector_type sector;
      logic [16:0]       factor_q;
      logic [16:0]       factor_t;
      logic [7:0]        sat;
      logic [7:0]        val;
   } hsvrgb_stage1_type;

   typedef struct packed {
      logic              valid;
      hsvrgb_sector_type sector;
      logic [7:0]        val;
   } hsvrgb_tag_type;

endpackage

FILE: rtl/hsvrgb_sector.sv
// ----------------------------------------------------------------------------
// HSV to RGB565 sector stage
// Splits hue * 6 into sector and fraction and forms the q and t factors.
// ----------------------------------------------------------------------------
module hsvrgb_sector
   import hsvrgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  hsvrgb_req_type    req,
   output hsvrgb_stage1_type stage
);

   logic [18:0]       prod;
   logic [15:0]       frac;
   logic              valid_ff;
   logic              valid_in;
   hsvrgb_sector_type sector_ff;
   hsvrgb_sector_type sector_in;
   logic [16:0]       factor_q_ff;
   logic [16:0]       factor_q_in;
   logic [16:0]       factor_t_ff;
   logic [16:0]       factor_t_in;
   logic [7:0]        sat_ff;
   logic [7:0]        val_ff;

   always_comb begin
      prod        = {1'b0, req.hue, 2'b00} + {2'b00, req.hue, 1'b0};
      frac        = prod[15:0];
      sector_in   = hsvrgb_sector_type'(prod[18:16]);
      factor_q_in = {1'b0, frac};
      factor_t_in = FRAC_ONE - {1'b0, frac};
      valid_in    = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff   <= sector_in;
      factor_q_ff <= factor_q_in;
      factor_t_ff <= factor_t_in;
      sat_ff      <= req.saturation;
      val_ff      <= req.brightness;
   end

   assign stage.valid    = valid_ff;
   assign stage.sector   = sector_ff;
   assign stage.factor_q = factor_q_ff;
   assign stage.factor_t = factor_t_ff;
   assign stage.sat      = sat_ff;
   assign stage.val      = val_ff;

endmodule

FILE: rtl/hsvrgb_scale.sv
// ----------------------------------------------------------------------------
// HSV to RGB565 channel scaler
// Two register stages forming round(val * (1 - sat * factor / (255 * 65536))),
// then a reciprocal divide by 255 with one correction step.
// ----------------------------------------------------------------------------
module hsvrgb_scale
   import hsvrgb_pkg::*;
(
   input  logic        clock,
   input  logic [7:0]  sat,
   input  logic [7:0]  val,
   input  logic [16:0] factor,
   output logic [7:0]  channel
);

   logic [24:0] sat_factor;
   logic [23:0] keep_ff;
   logic [23:0] keep_in;
   logic [7:0]  val_ff;
   logic [31:0] num;
   logic [15:0] high_ff;
   logic [15:0] high_in;
   logic [24:0] est;
   logic [8:0]  quot;
   logic [15:0] quot_255;
   logic [15:0] rem;
   logic [8:0]  quot_fix;

   always_comb begin
      sat_factor = {17'd0, sat} * {8'd0, factor};
      keep_in    = DIVISOR - sat_factor[23:0];
      num        = {24'd0, val_ff} * {8'd0, keep_ff} + HALF_DIV;
      high_in    = num[31:16];
   end

   always_ff @(posedge clock) begin
      keep_ff <= keep_in;
      val_ff  <= val;
      high_ff <= high_in;
   end

   // divide by 255: estimate with 257 / 65536, then correct once
   always_comb begin
      est      = {1'b0, high_ff, 8'd0} + {9'd0, high_ff};
      quot     = est[24:16];
      quot_255 = {quot[7:0], 8'd0} - {8'd0, quot[7:0]};
      rem      = high_ff - quot_255;
      quot_fix = (rem >= {8'd0, CHAN_MAX}) ? quot + 9'd1 : quot;
      channel  = quot_fix[7:0];
   end

endmodule

FILE: rtl/hsvrgb_pack.sv
// ----------------------------------------------------------------------------
// HSV to RGB565 output stage
// Picks v, p, q or t per channel by sector and registers the packed result.
// ----------------------------------------------------------------------------
module hsvrgb_pack
   import hsvrgb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  hsvrgb_tag_type tag,
   input  logic [7:0]     chan_p,
   input  logic [7:0]     chan_q,
   input  logic [7:0]     chan_t,
   output logic           strobe,
   output hsvrgb_rsp_type rsp
);

   logic           strobe_ff;
   logic           strobe_in;
   hsvrgb_rsp_type rsp_ff;
   hsvrgb_rsp_type rsp_in;
   logic [7:0]     r;
   logic [7:0]     g;
   logic [7:0]     b;

   always_comb begin
      case (tag.sector)
         SEC_RED_YEL: begin
            r = tag.val; g = chan_t;  b = chan_p;
         end
         SEC_YEL_GRN: begin
            r = chan_q;  g = tag.val; b = chan_p;
         end
         SEC_GRN_CYN: begin
            r = chan_p;  g = tag.val; b = chan_t;
         end
         SEC_CYN_BLU: begin
            r = chan_p;  g = chan_q;  b = tag.val;
         end
         SEC_BLU_MAG: begin
            r = chan_t;  g = chan_p;  b = tag.val;
         end
         default: begin
            r = tag.val; g = chan_p;  b = chan_q;
         end
      endcase
      rsp_in.red        = r;
      rsp_in.green      = g;
      rsp_in.blue       = b;
      rsp_in.packed_565 = {r[7:3], g[7:2], b[7:3]};
      strobe_in         = tag.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign strobe = strobe_ff;
   assign rsp    = rsp_ff;

endmodule

FILE: rtl/hsv_to_rgb565_convert_unit.sv
// ----------------------------------------------------------------------------
// HSV to RGB565 conversion unit
// Converts a 16-bit hue with 8-bit saturation and value into 8-bit red, green,
// blue and the packed RGB565 word, one pixel per clock.
//
// Request: drive req_payload with start high; the pixel transfers at the
// rising edge where start is high and busy is low. busy is always low, so
// a new pixel may be offered in every cycle.
// Response: rsp_strobe is high for exactly one cycle with rsp_payload; the
// receiver takes it at the edge ending that cycle and cannot hold it off.
// Throughput: one pixel per cycle, set by the four-stage pipeline
// (sector split, saturation product, value product, divide and select).
// Reset: synchronous, clears all valid bits; pixels in flight are dropped.
// Results leave in request order; there is no back-pressure to handle.
// ----------------------------------------------------------------------------
module hsv_to_rgb565_convert_unit
   import hsvrgb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  hsvrgb_req_type req_payload,
   output logic           rsp_strobe,
   output hsvrgb_rsp_type rsp_payload
);

   hsvrgb_stage1_type stage1;
   hsvrgb_tag_type    tag1;
   hsvrgb_tag_type    tag2_ff;
   hsvrgb_tag_type    tag3_ff;
   logic              accept;
   logic [7:0]        chan_p;
   logic [7:0]        chan_q;
   logic [7:0]        chan_t;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   hsvrgb_sector u_sector (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .stage  (stage1)
   );

   hsvrgb_scale u_scale_p (
      .clock   (clock),
      .sat     (stage1.sat),
      .val     (stage1.val),
      .factor  (FRAC_ONE),
      .channel (chan_p)
   );

   hsvrgb_scale u_scale_q (
      .clock   (clock),
      .sat     (stage1.sat),
      .val     (stage1.val),
      .factor  (stage1.factor_q),
      .channel (chan_q)
   );

   hsvrgb_scale u_scale_t (
      .clock   (clock),
      .sat     (stage1.sat),
      .val     (stage1.val),
      .factor  (stage1.factor_t),
      .channel (chan_t)
   );

   assign tag1.valid  = stage1.valid;
   assign tag1.sector = stage1.sector;
   assign tag1.val    = stage1.val;

   // advance the tag alongside the scaler stages
   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end else begin
         tag2_ff.valid <= tag1.valid;
         tag3_ff.valid <= tag2_ff.valid;
      end
      tag2_ff.sector <= tag1.sector;
      tag2_ff.val    <= tag1.val;
      tag3_ff.sector <= tag2_ff.sector;
      tag3_ff.val    <= tag2_ff.val;
   end

   hsvrgb_pack u_pack (
      .clock  (clock),
      .reset  (reset),
      .tag    (tag3_ff),
      .chan_p (chan_p),
      .chan_q (chan_q),
      .chan_t (chan_t),
      .strobe (rsp_strobe),
      .rsp    (rsp_payload)
   );

endmodule

FILE: rtl/hsvrgb_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB565 port checker
// Latency, ordering and output consistency seen at the unit's ports.
// ----------------------------------------------------------------------------
module hsvrgb_checker
   import hsvrgb_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           start,
   input logic           busy,
   input hsvrgb_req_type req_payload,
   input logic           rsp_strobe,
   input hsvrgb_rsp_type rsp_payload
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("response missing four cycles after request transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("response without matching request transfer");

   a_packed: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_payload.packed_565 ==
         {rsp_payload.red[7:3], rsp_payload.green[7:2], rsp_payload.blue[7:3]})
      else $error("packed word does not match channels");

   a_value_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.red == $past(req_payload.brightness, 4)) ||
         (rsp_payload.green == $past(req_payload.brightness, 4)) ||
         (rsp_payload.blue == $past(req_payload.brightness, 4)))
      else $error("no channel carries the brightness");

endmodule

bind hsv_to_rgb565_convert_unit hsvrgb_checker u_checker (.*);

FILE: dv/hsv_colour_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB565 colour checker
// Watches the pixel and colour channels of the conversion unit, works out the
// colour of every pixel that transfers in, and compares each colour that comes
// out, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module hsv_colour_checker
   import hsvrgb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           busy,
   input  hsvrgb_req_type req_payload,
   input  logic           rsp_strobe,
   input  hsvrgb_rsp_type rsp_payload,
   output int             mismatch_count,
   output int             colours_checked,
   output int             colours_pending
);

   hsvrgb_rsp_type expected_colours [$];

   initial begin
      mismatch_count  = 0;
      colours_checked = 0;
      colours_pending = 0;
   end

   // round half up of val * (1 - sat/255 * weight/65536)
   function automatic logic [7:0] attenuate(input logic [7:0] sat, input logic [7:0] val,
                                            input logic [16:0] weight);
      logic [63:0] keep;
      logic [63:0] scaled;
      logic [63:0] level;
      keep   = DIVISOR - sat * weight;
      scaled = val * keep + HALF_DIV;
      level  = scaled / DIVISOR;
      return level[7:0];
   endfunction

   function automatic hsvrgb_rsp_type predict_colour(input hsvrgb_req_type px);
      logic [18:0]       turns;
      logic [16:0]       frac;
      hsvrgb_sector_type sector;
      logic [7:0]        v_lvl, p_lvl, q_lvl, t_lvl, r, g, b;
      hsvrgb_rsp_type    colour;
      turns  = px.hue * 19'd6;
      sector = hsvrgb_sector_type'(turns[18:16]);
      frac   = {1'b0, turns[15:0]};
      v_lvl  = px.brightness;
      p_lvl  = attenuate(px.saturation, px.brightness, FRAC_ONE);
      q_lvl  = attenuate(px.saturation, px.brightness, frac);
      t_lvl  = attenuate(px.saturation, px.brightness, FRAC_ONE - frac);
      case (sector)
         SEC_RED_YEL: begin r = v_lvl; g = t_lvl; b = p_lvl; end
         SEC_YEL_GRN: begin r = q_lvl; g = v_lvl; b = p_lvl; end
         SEC_GRN_CYN: begin r = p_lvl; g = v_lvl; b = t_lvl; end
         SEC_CYN_BLU: begin r = p_lvl; g = q_lvl; b = v_lvl; end
         SEC_BLU_MAG: begin r = t_lvl; g = p_lvl; b = v_lvl; end
         default: begin r = v_lvl; g = p_lvl; b = q_lvl; end
      endcase
      colour.red        = r;
      colour.green      = g;
      colour.blue       = b;
      colour.packed_565 = {r[7:3], g[7:2], b[7:3]};
      return colour;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin : watch
      hsvrgb_rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_colours.size() == 0) begin
               report_mismatch($sformatf("colour 0x%0h with no pixel outstanding",
                                         rsp_payload));
            end else begin
               want = expected_colours.pop_front();
               check_field("red", 16'(rsp_payload.red), 16'(want.red));
               check_field("green", 16'(rsp_payload.green), 16'(want.green));
               check_field("blue", 16'(rsp_payload.blue), 16'(want.blue));
               check_field("packed_565", rsp_payload.packed_565, want.packed_565);
               colours_checked++;
            end
         end
         if (start && !busy) begin
            expected_colours.push_back(predict_colour(req_payload));
         end
      end
      colours_pending = expected_colours.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB565 conversion unit testbench
// Drives a directed set of pixels (hue extremes, every sector and its edges,
// saturation and value extremes), then random pixels in three phases of
// sender gaps, draining the pipeline between phases. The colour checker
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import hsvrgb_pkg::*;

   localparam int PHASE_PIXELS = 284;

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   hsvrgb_req_type req_payload;
   logic           rsp_strobe;
   hsvrgb_rsp_type rsp_payload;

   int mismatch_count;
   int colours_checked;
   int colours_pending;
   int pixels_sent;
   int directed_pixels;

   hsv_to_rgb565_convert_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   hsv_colour_checker colour_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_payload     (req_payload),
      .rsp_strobe      (rsp_strobe),
      .rsp_payload     (rsp_payload),
      .mismatch_count  (mismatch_count),
      .colours_checked (colours_checked),
      .colours_pending (colours_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("FAILURE");
      $finish;
   end

   // first hue of sector k, i.e. ceil(k * 65536 / 6)
   function automatic int boundary_hue(input int k);
      return (k * 65536 + 5) / 6;
   endfunction

   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(1, 4));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_hue();
      case ($urandom_range(0, 9))
         0, 1: return 16'(boundary_hue($urandom_range(1, 5)) + $urandom_range(0, 4) - 2);
         2: return 16'($urandom_range(65530, 65535));
         3: return 16'($urandom_range(0, 5));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
                             input logic [7:0] val, input int gap_pct);
      hsvrgb_req_type px;
      px.hue        = hue;
      px.saturation = sat;
      px.brightness = val;
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      start <= 1'b0;
      while (colours_pending != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int k;
      int phase;
      int gap_pct;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      pixels_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_pixel(16'd0, 8'd255, 8'd255, 0);
      send_pixel(16'd65535, 8'd255, 8'd255, 0);
      send_pixel(16'd65535, 8'd128, 8'd200, 0);
      send_pixel(16'hAAAA, 8'd0, 8'd173, 0);
      send_pixel(16'h5555, 8'd0, 8'd0, 0);
      send_pixel(16'h1234, 8'd255, 8'd0, 0);
      for (k = 0; k < 6; k++) begin
         send_pixel(16'(boundary_hue(k) + 5461), 8'd255, 8'd255, 0);
      end
      for (k = 1; k < 6; k++) begin
         send_pixel(16'(boundary_hue(k) - 1), 8'd200, 8'd255, 0);
         send_pixel(16'(boundary_hue(k)), 8'd200, 8'd255, 0);
      end
      send_pixel(16'hFFFF, 8'hFF, 8'h01, 0);
      send_pixel(16'h8000, 8'h55, 8'hAA, 0);
      directed_pixels = pixels_sent;
      drain_pipeline();

      for (phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 38 : (phase == 1) ? 63 : 0;
         repeat (PHASE_PIXELS) begin
            send_pixel(random_hue(), random_level(), random_level(), gap_pct);
         end
         drain_pipeline();
      end

      repeat (10) @(posedge clock);
      $display("Converted %0d pixels: %0d directed over hue edges and sector midpoints,",
               pixels_sent, directed_pixels);
      $display("the rest random with sender gaps of 38, 63 and 0 percent; %0d colours compared.",
               colours_checked);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_sector.sv
rtl/hsvrgb_scale.sv
rtl/hsvrgb_pack.sv
rtl/hsv_to_rgb565_convert_unit.sv
rtl/hsvrgb_checker.sv
dv/hsv_colour_checker.sv
dv/testbench.sv
